@@ rtl/core/pc_cal_pkg.sv @@
`timescale 1ns / 1ps

package pc_cal_pkg;

	localparam int DVD_W = 32;
	localparam int DVS_W = 17;
	localparam int DIV_CNT_W = $clog2(DVD_W);

	localparam logic signed [15:0] GAIN_UNITY = 16'sd10000;
	localparam logic [14:0] REF_RESET = 15'd4200;
	localparam logic [14:0] VAL_MAX = 15'h7fff;
	localparam logic [DVD_W-1:0] Q_POS_MAX = 32'd32767;
	localparam logic [DVD_W-1:0] Q_NEG_MAX = 32'd32768;
	localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
	localparam logic signed [15:0] OFFSET_MAX = 16'sh7fff;
	localparam logic signed [15:0] GAIN_MIN = 16'sh8000;

	// x / 10000 as ((x >> 4) * SCALE_MUL) >> SCALE_SHIFT, exact for x below 2^31
	localparam int SCALE_SHIFT = 37;
	localparam logic [27:0] SCALE_MUL = 28'd219902326;

	typedef enum logic [1:0] {
		OP_MEASURE = 2'd0,
		OP_ZERO    = 2'd1,
		OP_HIGH    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_ZERO_DIV = 2'd1,
		STAT_SAT      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SUM,
		S_MUL,
		S_SCALE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FIN
	} state_t;

endpackage

@@ rtl/core/pc_cal_ram.sv @@
`timescale 1ns / 1ps

module pc_cal_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 6
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/pc_cal_div.sv @@
`timescale 1ns / 1ps

module pc_cal_div
	import pc_cal_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DVS_W:0]       shifted;
	logic [DVS_W:0]       diff;
	logic                 ge;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/core/per_channel_two_point_calibration.sv @@
`timescale 1ns / 1ps

// Per-cell two-point calibration. Each cell keeps a signed offset and a gain
// scaled so that 10000 is unity, held in two small synchronous RAMs with a
// registered read; per-entry valid flags make unwritten cells read back as zero
// offset and unity gain right after reset. A request with op 1 stores the
// negated sample as offset, op 2 sets gain to reference_level * 10000 divided
// by (sample + offset), op 0 returns (sample + offset) * gain / 10000 clamped
// to 0..32767. Requests are handled one at a time: high-point requests go
// through the 32-step serial divider; measure requests skip it, the divide
// by 10000 being a reciprocal multiply; zero-point, unused op, zero divisor
// and out-of-range cell requests skip both. A finished result sits in an
// output register, so the next request is taken while it waits.
module per_channel_two_point_calibration
	import pc_cal_pkg::*;
#(
	parameter int CELL_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [2:0]  cell_req,
	input  logic signed [15:0] sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] calibrated_value,
	output logic [1:0]  status
);

	localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	state_t state_q, state_d;

	logic [14:0]            ref_q;
	logic [1:0]             op_q;
	logic [AW-1:0]          addr_q;
	logic                   in_range_q;
	logic signed [15:0]     sample_q;
	logic signed [16:0]     sum_q;
	logic signed [15:0]     gain_q;
	logic signed [32:0]     prod_q;
	logic                   neg_q;
	logic [DVD_W-1:0]       scale_q;
	logic [CELL_COUNT-1:0]  gain_vld_q;
	logic [CELL_COUNT-1:0]  off_vld_q;
	logic                   out_valid_q;
	logic [14:0]            value_q;
	logic [1:0]             status_q;

	logic [15:0]            gain_rdata;
	logic [15:0]            off_rdata;
	logic signed [15:0]     gain_eff;
	logic signed [15:0]     off_eff;
	logic signed [16:0]     sum_d;
	logic signed [32:0]     mul_a;
	logic signed [32:0]     mul_b;
	logic signed [32:0]     neg_prod;
	logic signed [16:0]     neg_sum;
	logic [DVD_W-1:0]       div_dividend;
	logic [DVS_W-1:0]       div_divisor;
	logic [26:0]            scale_in;
	logic [54:0]            scale_prod;
	logic                   div_start;
	logic                   div_done;
	logic [DVD_W-1:0]       quo;
	logic                   accept;
	logic                   out_free;
	logic                   fire;
	logic                   gain_we;
	logic                   off_we;
	logic [15:0]            gain_wdata;
	logic [15:0]            off_wdata;
	logic [14:0]            res_val;
	logic [1:0]             res_stat;
	logic                   go_div;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	pc_cal_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_gain_ram (
		.clk   (clk),
		.we    (gain_we),
		.waddr (addr_q),
		.wdata (gain_wdata),
		.raddr (addr_q),
		.rdata (gain_rdata)
	);

	pc_cal_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_off_ram (
		.clk   (clk),
		.we    (off_we),
		.waddr (addr_q),
		.wdata (off_wdata),
		.raddr (addr_q),
		.rdata (off_rdata)
	);

	pc_cal_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// read side: unwritten cells fall back to reset values
	assign gain_eff = gain_vld_q[addr_q] ? $signed(gain_rdata) : GAIN_UNITY;
	assign off_eff  = off_vld_q[addr_q] ? $signed(off_rdata) : 16'sd0;
	assign sum_d    = {sample_q[15], sample_q} + {off_eff[15], off_eff};

	// shared multiplier: sum * gain or reference * unity
	always_comb begin
		if (op_q == OP_MEASURE) begin
			mul_a = {{16{sum_q[16]}}, sum_q};
			mul_b = {{17{gain_q[15]}}, gain_q};
		end else begin
			mul_a = {18'd0, ref_q};
			mul_b = {{17{GAIN_UNITY[15]}}, GAIN_UNITY};
		end
	end

	assign neg_prod     = -prod_q;
	assign neg_sum      = -sum_q;
	assign div_dividend = prod_q[32] ? neg_prod[DVD_W-1:0] : prod_q[DVD_W-1:0];
	assign div_divisor  = sum_q[16] ? neg_sum : sum_q;

	assign scale_in   = div_dividend[30:4];
	assign scale_prod = scale_in * SCALE_MUL;

	assign go_div = in_range_q && ((op_q == OP_MEASURE)
		|| (op_q == OP_HIGH && sum_d != '0));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		fire      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_SUM;
			end
			S_SUM: begin
				state_d = go_div ? S_MUL : S_FIN;
			end
			S_MUL: begin
				state_d = (op_q == OP_MEASURE) ? S_SCALE : S_DIV_GO;
			end
			S_SCALE: begin
				state_d = S_FIN;
			end
			S_DIV_GO: begin
				div_start = 1'b1;
				state_d   = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					fire    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result and write-back
	always_comb begin
		res_val    = '0;
		res_stat   = STAT_OK;
		gain_wdata = '0;
		off_wdata  = '0;
		gain_we    = 1'b0;
		off_we     = 1'b0;
		if (in_range_q) begin
			unique case (op_t'(op_q))
				OP_MEASURE: begin
					if (!neg_q) begin
						if (scale_q > Q_POS_MAX) begin
							res_val  = VAL_MAX;
							res_stat = STAT_SAT;
						end else begin
							res_val = scale_q[14:0];
						end
					end
				end
				OP_ZERO: begin
					off_we = fire;
					if (sample_q == SAMPLE_MIN) begin
						off_wdata = OFFSET_MAX;
						res_stat  = STAT_SAT;
					end else begin
						off_wdata = -sample_q;
					end
				end
				OP_HIGH: begin
					if (sum_q == '0) begin
						res_stat = STAT_ZERO_DIV;
					end else begin
						gain_we = fire;
						if (!neg_q) begin
							if (quo > Q_POS_MAX) begin
								gain_wdata = OFFSET_MAX;
								res_stat   = STAT_SAT;
							end else begin
								gain_wdata = quo[15:0];
							end
						end else begin
							if (quo > Q_NEG_MAX) begin
								gain_wdata = GAIN_MIN;
								res_stat   = STAT_SAT;
							end else begin
								gain_wdata = -quo[15:0];
							end
						end
					end
				end
				default: begin
					res_val = '0;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= REF_RESET;
			gain_vld_q  <= '0;
			off_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ref_q <= cfg_wdata;
			end
			if (gain_we) begin
				gain_vld_q[addr_q] <= 1'b1;
			end
			if (off_we) begin
				off_vld_q[addr_q] <= 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op;
			addr_q     <= AW'(cell_req);
			in_range_q <= 32'(cell_req) < CELL_COUNT;
			sample_q   <= sample;
		end
		if (state_q == S_SUM) begin
			sum_q  <= sum_d;
			gain_q <= gain_eff;
		end
		if (state_q == S_MUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_SCALE) begin
			scale_q <= {{(DVD_W - 18){1'b0}}, scale_prod[54:SCALE_SHIFT]};
		end
		if (state_q == S_SCALE || state_q == S_DIV_GO) begin
			neg_q <= (op_q == OP_MEASURE) ? prod_q[32] : sum_q[16];
		end
		if (fire) begin
			value_q  <= res_val;
			status_q <= res_stat;
		end
	end

	assign out_valid        = out_valid_q;
	assign calibrated_value = value_q;
	assign status           = status_q;

endmodule
